// ===== sv/isqrt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isqrt_pkg
// shared constants and helpers for the integer square root block
// ----------------------------------------------------------------------------
package isqrt_pkg;

    // width of the root field on the result channel
    localparam int ROOT_BITS = 16;

    // number of root bits, one cell each, for a given radicand width
    function automatic int root_steps(input int radicand_bits);
        return (radicand_bits + 1) >> 1;
    endfunction

endpackage

// ===== sv/isqrt_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isqrt_cell
// one restoring square root step: settles a single root bit and hands the
// partial remainder and partial root on to the next cell
// ----------------------------------------------------------------------------
module isqrt_cell #(
    parameter int RADICAND_BITS = 31,
    parameter int STEP          = 0
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     up_valid,
    output logic                     up_ready,
    input  logic [RADICAND_BITS-1:0] up_rem,
    input  logic [RADICAND_BITS-1:0] up_res,
    output logic                     dn_valid,
    input  logic                     dn_ready,
    output logic [RADICAND_BITS-1:0] dn_rem,
    output logic [RADICAND_BITS-1:0] dn_res
);

    localparam int STEPS = isqrt_pkg::root_steps(RADICAND_BITS);
    localparam int SHIFT = 2 * (STEPS - 1 - STEP);
    localparam logic [RADICAND_BITS-1:0] BIT_VAL = RADICAND_BITS'(1) << SHIFT;

    logic                     valid_reg;
    logic [RADICAND_BITS-1:0] rem_reg;
    logic [RADICAND_BITS-1:0] rem_next;
    logic [RADICAND_BITS-1:0] res_reg;
    logic [RADICAND_BITS-1:0] res_next;
    logic [RADICAND_BITS:0]   trial;
    logic                     take;

    // trial subtraction of (res + bit) from the remainder
    always_comb
    begin
        trial = {1'b0, up_res} + {1'b0, BIT_VAL};
        take  = ({1'b0, up_rem} >= trial);
        if (take)
        begin
            rem_next = up_rem - trial[RADICAND_BITS-1:0];
            res_next = (up_res >> 1) + BIT_VAL;
        end
        else
        begin
            rem_next = up_rem;
            res_next = up_res >> 1;
        end
    end

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            rem_reg <= rem_next;
            res_reg <= res_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_rem   = rem_reg;
    assign dn_res   = res_reg;

endmodule

// ===== sv/integer_square_root_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_square_root_top
// floor square root of an unsigned radicand, one root bit per cell
// ----------------------------------------------------------------------------
// Each radicand beat returns one root beat, the floor of its square root.
// The work runs down a chain of (RADICAND_BITS+1)/2 cells (16 at the default
// width), each settling one root bit from the most significant down, followed
// by an output register. A new radicand can be taken every cycle while the
// chain has room. When the result side stalls, empty cells still close up,
// so the chain keeps taking beats until every cell is full. The root field
// carries the low 16 bits of the root when RADICAND_BITS is set above 32.
module integer_square_root_top #(
    parameter int RADICAND_BITS = 31
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // radicand channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [RADICAND_BITS-1:0]            radicand,
    // root channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [isqrt_pkg::ROOT_BITS-1:0]     root
);

    localparam int STEPS = isqrt_pkg::root_steps(RADICAND_BITS);

    // chain links: index k feeds cell k, index STEPS feeds the output register
    logic                     link_valid [STEPS+1];
    logic                     link_ready [STEPS+1];
    logic [RADICAND_BITS-1:0] link_rem   [STEPS+1];
    logic [RADICAND_BITS-1:0] link_res   [STEPS+1];

    logic                            out_valid_reg;
    logic [isqrt_pkg::ROOT_BITS-1:0] root_reg;
    logic                            out_ready;

    // head of the chain: full radicand as remainder, empty partial root
    assign link_valid[0] = in_valid;
    assign link_rem[0]   = radicand;
    assign link_res[0]   = '0;
    assign in_stall      = !link_ready[0];

    for (genvar k = 0; k < STEPS; k++)
    begin : g_cell
        isqrt_cell #(
            .RADICAND_BITS (RADICAND_BITS),
            .STEP          (k)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (link_valid[k]),
            .up_ready (link_ready[k]),
            .up_rem   (link_rem[k]),
            .up_res   (link_res[k]),
            .dn_valid (link_valid[k+1]),
            .dn_ready (link_ready[k+1]),
            .dn_rem   (link_rem[k+1]),
            .dn_res   (link_res[k+1])
        );
    end

    // output register parts the chain from the result side
    assign out_ready         = !out_valid_reg || !out_stall;
    assign link_ready[STEPS] = out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= link_valid[STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && link_valid[STEPS])
        begin
            root_reg <= isqrt_pkg::ROOT_BITS'(link_res[STEPS]);
        end
    end

    assign out_valid = out_valid_reg;
    assign root      = root_reg;

    // the chain only pushes back once the output and every cell are full
    a_stall_only_when_full : assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid_reg && out_stall && link_valid[STEPS]))
        else $error("radicand stalled while the chain still had room");

    // a free output register lets a beat in at the head
    a_free_output_takes : assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid_reg || !out_stall) |-> !in_stall)
        else $error("radicand stalled with the output register free");

    // final remainder x - r*r never exceeds 2r
    a_final_remainder : assert property (@(posedge clk) disable iff (!rst_n)
        link_valid[STEPS] |->
            ({1'b0, link_rem[STEPS]} <= {link_res[STEPS], 1'b0}))
        else $error("remainder too large at end of chain");

endmodule

// ===== tb/integer_square_root_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_square_root_top_tb
// self-checking bench for the floor square root pipeline
// ----------------------------------------------------------------------------
// Radicand beats are queued up front: a directed set covering the field
// extremes and perfect-square boundaries, then a random mix that includes
// values at and next to perfect squares. A clocked driver sends them in bursts
// with random gaps. Each accepted radicand has its root worked out by a
// restoring square root in the bench and queued. A clocked monitor checks
// every root beat against the oldest queued root. The result side stalls
// on its own windowed pattern, with one long hold that fills the chain.
// Two drain markers in the queue make the sender wait for an empty pipe.
// ----------------------------------------------------------------------------
module integer_square_root_top_tb;

    localparam int RAD_BITS   = 31;
    localparam int CLK_HALF   = 5;
    localparam int TAIL_WAIT  = 40;
    localparam int LONG_HOLD  = 250;
    localparam int HOLD_AFTER = 300;
    localparam int RANDOM_CNT = 1030;

    typedef logic [RAD_BITS-1:0]           radicand_t;
    typedef logic [isqrt_pkg::ROOT_BITS-1:0] root_t;

    // a drain entry makes the sender wait until every root has come back
    typedef struct {
        bit        drain;
        radicand_t value;
    } pending_beat_t;

    // receiver stall styles, one picked per window
    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_TOGGLE
    } stall_style_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    radicand_t  radicand = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    root_t      root;

    pending_beat_t radicand_queue[$];
    root_t         expected_roots[$];
    int            error_count = 0;
    int            roots_seen = 0;

    integer_square_root_top #(
        .RADICAND_BITS (RAD_BITS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .radicand  (radicand),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .root      (root)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // restoring square root, one root bit settled per pass from the top down
    function automatic root_t floor_sqrt(input radicand_t x);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] one;
        rem = 64'(x);
        res = '0;
        one = 64'd1 << (((RAD_BITS - 1) / 2) * 2);
        while (one != 0)
        begin
            if (rem >= res + one)
            begin
                rem = rem - (res + one);
                res = (res >> 1) + one;
            end
            else
            begin
                res = res >> 1;
            end
            one = one >> 2;
        end
        return root_t'(res);
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $realtime, what);
        error_count++;
    endtask

    task automatic queue_radicand(input radicand_t value);
        pending_beat_t beat;
        beat.drain = 1'b0;
        beat.value = value;
        radicand_queue.push_back(beat);
    endtask

    task automatic queue_drain();
        pending_beat_t beat;
        beat.drain = 1'b1;
        beat.value = '0;
        radicand_queue.push_back(beat);
    endtask

    // random radicand, partly near perfect squares where off-by-one bugs live
    function automatic radicand_t pick_radicand();
        logic [63:0] r;
        logic [63:0] v;
        int          kind;
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1, 2, 3: v = 64'($urandom);
            4, 5:
            begin
                r = 64'($urandom_range(0, 46340));
                case ($urandom_range(0, 3))
                    0: v = r * r;
                    1: v = (r == 0) ? 64'd0 : r * r - 1;
                    2: v = r * r + 1;
                    default: v = r * r + 2 * r;
                endcase
            end
            6: v = 64'($urandom_range(0, 1023));
            7: v = ((64'd1 << RAD_BITS) - 64'd1) - 64'($urandom_range(0, 4095));
            8: v = 64'd1 << $urandom_range(0, RAD_BITS - 1);
            default: v = 64'($urandom) >> $urandom_range(0, 31);
        endcase
        if (v > (64'd1 << RAD_BITS) - 64'd1)
            v = (64'd1 << RAD_BITS) - 64'd1;
        return radicand_t'(v);
    endfunction

    // --------------------------------------------------------------------
    // driver: bursts of beats with random gaps, holds while stalled
    // --------------------------------------------------------------------
    int burst_left = 1;
    int gap_left = 0;

    always @(posedge clk or negedge rst_n)
    begin : radicand_driver
        logic          next_valid;
        pending_beat_t next_beat;
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            radicand   <= '0;
            burst_left <= 1;
            gap_left   <= 0;
        end
        else
        begin
            // beat taken on this edge: its root joins the expected list
            if (in_valid && !in_stall)
                expected_roots.push_back(floor_sqrt(radicand));

            // payload may only move when nothing is held under stall
            if (!in_valid || !in_stall)
            begin
                next_valid = 1'b0;
                if (radicand_queue.size() != 0 && radicand_queue[0].drain &&
                    expected_roots.size() == 0)
                    void'(radicand_queue.pop_front());

                if (gap_left != 0)
                begin
                    gap_left <= gap_left - 1;
                end
                else if (radicand_queue.size() != 0 && !radicand_queue[0].drain)
                begin
                    next_valid = 1'b1;
                    next_beat  = radicand_queue.pop_front();
                    radicand   <= next_beat.value;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 30);
                        // a third of bursts run straight on with no gap
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 :
                                    $urandom_range(1, 12);
                    end
                    else
                    begin
                        burst_left <= burst_left - 1;
                    end
                end
                in_valid <= next_valid;
            end
        end
    end

    // --------------------------------------------------------------------
    // result stall: windowed pattern plus one long hold to fill the chain
    // --------------------------------------------------------------------
    stall_style_t stall_style = STALL_NONE;
    int           window_left = 0;
    int           hold_left = 0;
    bit           hold_done = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall   <= 1'b0;
            stall_style <= STALL_NONE;
            window_left <= 0;
            hold_left   <= 0;
            hold_done   <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && roots_seen >= HOLD_AFTER)
        begin
            // long hold while the sender keeps offering beats
            out_stall <= 1'b1;
            hold_left <= LONG_HOLD;
            hold_done <= 1'b1;
        end
        else
        begin
            if (window_left == 0)
            begin
                stall_style <= stall_style_t'($urandom_range(0, 3));
                window_left <= $urandom_range(16, 80);
            end
            else
            begin
                window_left <= window_left - 1;
            end
            case (stall_style)
                STALL_NONE:   out_stall <= 1'b0;
                STALL_LIGHT:  out_stall <= ($urandom_range(0, 7) == 0);
                STALL_HEAVY:  out_stall <= ($urandom_range(0, 3) != 0);
                STALL_TOGGLE: out_stall <= !out_stall;
                default:      out_stall <= 1'b0;
            endcase
        end
    end

    // --------------------------------------------------------------------
    // monitor: each root beat against the oldest expected root
    // --------------------------------------------------------------------
    always @(posedge clk)
    begin : root_monitor
        root_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            roots_seen <= roots_seen + 1;
            if (expected_roots.size() == 0)
            begin
                report_mismatch($sformatf("root %0d with no radicand pending", root));
            end
            else
            begin
                want = expected_roots.pop_front();
                if (root !== want)
                    report_mismatch($sformatf("root got %0d want %0d", root, want));
            end
        end
    end

    // --------------------------------------------------------------------
    // stimulus and end of run
    // --------------------------------------------------------------------
    initial
    begin
        // field extremes and perfect-square edges
        queue_radicand(31'd0);
        queue_radicand(31'd1);
        queue_radicand(31'd2);
        queue_radicand(31'd3);
        queue_radicand(31'd4);
        queue_radicand(31'd5);
        queue_radicand(31'd8);
        queue_radicand(31'd9);
        queue_radicand(31'd15);
        queue_radicand(31'd16);
        queue_radicand(31'd17);
        queue_radicand(31'd65535);
        queue_radicand(31'd65536);
        queue_radicand(31'd2147395599);
        queue_radicand(31'd2147395600);
        queue_radicand(31'd2147483646);
        queue_radicand(31'd2147483647);
        queue_radicand(31'h4000_0000);
        queue_radicand(31'h3FFF_FFFF);
        queue_radicand(31'h5555_5555);
        queue_radicand(31'h2AAA_AAAA);
        for (int i = 0; i < RANDOM_CNT; i++)
        begin
            // sender waits for an empty pipe twice along the way
            if (i == RANDOM_CNT / 3 || i == (2 * RANDOM_CNT) / 3)
                queue_drain();
            queue_radicand(pick_radicand());
        end

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (radicand_queue.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_roots.size() != 0)
            @(posedge clk);
        repeat (TAIL_WAIT) @(posedge clk);

        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // watchdog well beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/isqrt_pkg.sv
sv/isqrt_cell.sv
sv/integer_square_root_top.sv
tb/integer_square_root_top_tb.sv
